@@ design/bpet_pkg.sv @@
`timescale 1ns / 1ps
// Package for the button press event tracker.
// Holds sizes, command/select/register codes, flag bits and shared types.
package bpet_pkg;

    localparam int BUTTONS     = 6;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int LIM_W       = 8;
    localparam int HOLD_W      = LIM_W + 1;
    localparam int FLAG_W      = 6;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_SEED  = 2'd3;

    localparam logic [2:0] SEL_PRESS     = 3'd0;
    localparam logic [2:0] SEL_LONG      = 3'd1;
    localparam logic [2:0] SEL_SHORT_REL = 3'd2;
    localparam logic [2:0] SEL_LONG_REL  = 3'd3;
    localparam logic [2:0] SEL_REL       = 3'd4;
    localparam logic [2:0] SEL_FLAGS     = 3'd5;

    localparam logic [1:0] CFG_LONG_TICKS   = 2'd0;
    localparam logic [1:0] CFG_ABORT_MASK   = 2'd1;
    localparam logic [1:0] CFG_ABORT_BUTTON = 2'd2;

    localparam logic [7:0] RST_LONG_TICKS   = 8'd200;
    localparam logic [5:0] RST_ABORT_MASK   = 6'd2;
    localparam logic [2:0] RST_ABORT_BUTTON = 3'd0;

    localparam logic [FLAG_W-1:0] FL_PRESSED   = 6'h01;
    localparam logic [FLAG_W-1:0] FL_PRESS_EV  = 6'h02;
    localparam logic [FLAG_W-1:0] FL_LONG_EV   = 6'h04;
    localparam logic [FLAG_W-1:0] FL_SHORT_REL = 6'h08;
    localparam logic [FLAG_W-1:0] FL_LONG_REL  = 6'h10;
    localparam logic [FLAG_W-1:0] FL_RELEASED  = 6'h20;

    typedef logic [FLAG_W-1:0]      t_flags;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        t_count press;
        t_count long_press;
        t_count short_rel;
        t_count long_rel;
        t_count rel;
    } t_cnt_set;

    typedef struct packed {
        logic             tick;
        logic             seed;
        logic             wr_en;
        logic             rd_clr;
        logic [2:0]       sel;
        logic [LIM_W-1:0] lim;
        logic [15:0]      wval;
    } t_lane_ctl;

endpackage

@@ design/bpet_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the button press event tracker.
// Input word channel and result word channel; no dependencies.
interface bpet_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [5:0]  raw_pressed;
    logic [3:0]  button_index;
    logic [2:0]  counter_select;
    logic [15:0] write_value;
    logic        clear_press_count;

    modport source (output valid, command, raw_pressed, button_index, counter_select,
                    write_value, clear_press_count, input ready);
    modport sink   (input valid, command, raw_pressed, button_index, counter_select,
                    write_value, clear_press_count, output ready);
endinterface

interface bpet_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_value;
    logic        pressed;
    logic        abort;
    logic        index_error;

    modport source (output valid, read_value, pressed, abort, index_error, input ready);
    modport sink   (input valid, read_value, pressed, abort, index_error, output ready);
endinterface

@@ design/bpet_lane.sv @@
`timescale 1ns / 1ps
// One button lane: hold timer, state flags and event counters.
// Depends on bpet_pkg.
module bpet_lane
    import bpet_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    input  logic      i_was,
    input  logic      i_now,
    input  logic      i_raw,
    output t_flags    o_flags,
    output t_flags    o_flags_nxt,
    output t_cnt_set  o_cnt
);

    logic [HOLD_W-1:0] r_hold, n_hold;
    t_flags            r_flags, n_flags;
    t_cnt_set          r_cnt, n_cnt;
    logic [HOLD_W-1:0] lim_ext;

    assign lim_ext = {1'b0, i_ctl.lim};

    always_comb begin
        n_hold  = r_hold;
        n_flags = r_flags;
        n_cnt   = r_cnt;
        if (i_ctl.seed) begin
            n_cnt = '0;
            if (i_raw) begin
                n_flags = FL_PRESSED;
                n_hold  = lim_ext + HOLD_W'(1);
            end else begin
                n_flags = FL_RELEASED;
                n_hold  = '0;
            end
        end else if (i_ctl.tick) begin
            if (i_now) begin
                if (!i_was) begin
                    n_hold      = '0;
                    n_flags     = FL_PRESSED | FL_PRESS_EV;
                    n_cnt.press = r_cnt.press + COUNT_WIDTH'(1);
                end else if (r_hold < lim_ext) begin
                    n_flags = FL_PRESSED;
                    n_hold  = r_hold + HOLD_W'(1);
                end else if (r_hold == lim_ext) begin
                    n_flags          = FL_PRESSED | FL_LONG_EV;
                    n_hold           = r_hold + HOLD_W'(1);
                    n_cnt.long_press = r_cnt.long_press + COUNT_WIDTH'(1);
                end else begin
                    n_flags = FL_PRESSED;
                end
            end else if (i_was) begin
                if (r_hold >= lim_ext) begin
                    n_flags        = FL_RELEASED | FL_LONG_REL;
                    n_cnt.long_rel = r_cnt.long_rel + COUNT_WIDTH'(1);
                end else begin
                    n_flags         = FL_RELEASED | FL_SHORT_REL;
                    n_cnt.short_rel = r_cnt.short_rel + COUNT_WIDTH'(1);
                end
                n_cnt.rel = r_cnt.rel + COUNT_WIDTH'(1);
            end else begin
                n_flags = FL_RELEASED;
            end
        end else if (i_ctl.wr_en) begin
            case (i_ctl.sel)
                SEL_PRESS:     n_cnt.press      = COUNT_WIDTH'(i_ctl.wval);
                SEL_LONG:      n_cnt.long_press = COUNT_WIDTH'(i_ctl.wval);
                SEL_SHORT_REL: n_cnt.short_rel  = COUNT_WIDTH'(i_ctl.wval);
                SEL_LONG_REL:  n_cnt.long_rel   = COUNT_WIDTH'(i_ctl.wval);
                SEL_REL:       n_cnt.rel        = COUNT_WIDTH'(i_ctl.wval);
                SEL_FLAGS:     n_flags          = i_ctl.wval[FLAG_W-1:0];
                default:       n_flags          = r_flags;
            endcase
        end else if (i_ctl.rd_clr) begin
            n_cnt.press = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_flags <= FL_RELEASED;
            r_cnt   <= '0;
        end else begin
            r_hold  <= n_hold;
            r_flags <= n_flags;
            r_cnt   <= n_cnt;
        end
    end

    assign o_flags     = r_flags;
    assign o_flags_nxt = n_flags;
    assign o_cnt       = r_cnt;

endmodule

@@ design/button_press_event_tracker_core.sv @@
`timescale 1ns / 1ps
// Top level of the button press event tracker: input register, debounce,
// per-button lanes, result register. Depends on bpet_pkg, bpet_ifs, bpet_lane.
//
// Takes one command word per clock while the sink keeps up and returns exactly
// one result word per command. A word is held in the input register, where the
// debounce, lane state update and read mux run combinationally, and its result
// is loaded into the output register, which presents the result word; a stalled
// sink holds both registers, and one word per cycle is sustained while the sink
// keeps up. Configuration writes take effect at the next edge and must only be
// issued while no command is in flight.
module button_press_event_tracker_core
    import bpet_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    bpet_in_if.sink     i_in_word,
    bpet_out_if.source  o_out_word
);

    logic [LIM_W-1:0] r_lim;
    logic [5:0]       r_abort_mask;
    logic [2:0]       r_abort_btn;

    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [5:0]  r_raw;
    logic [3:0]  r_idx;
    logic [2:0]  r_sel;
    logic [15:0] r_wval;
    logic        r_clr;

    logic        r_init, n_init;
    logic [5:0]  r_prev_raw, n_prev_raw;
    logic [5:0]  r_deb, n_deb;

    logic        r_out_valid;
    logic [15:0] r_rd_val, n_rd_val;
    logic        r_pressed, n_pressed;
    logic        r_abort, n_abort;
    logic        r_idx_err, n_idx_err;

    logic        adv, fire, idx_ok, acc_ok;
    logic [IDX_W-1:0] lane_idx;
    t_lane_ctl   lane_ctl [BUTTONS];
    t_flags      lane_flags [BUTTONS];
    t_flags      lane_flags_nxt [BUTTONS];
    t_cnt_set    lane_cnt [BUTTONS];
    t_flags      ab_flags;
    t_cnt_set    sel_cnt;
    t_flags      sel_flags;

    assign adv               = !r_out_valid || o_out_word.ready;
    assign fire              = r_in_valid && adv;
    assign i_in_word.ready   = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim        <= RST_LONG_TICKS;
            r_abort_mask <= RST_ABORT_MASK;
            r_abort_btn  <= RST_ABORT_BUTTON;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_TICKS:   r_lim        <= i_cfg_data;
                CFG_ABORT_MASK:   r_abort_mask <= i_cfg_data[5:0];
                CFG_ABORT_BUTTON: r_abort_btn  <= i_cfg_data[2:0];
                default:          r_lim        <= r_lim;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_word.ready) begin
            r_in_valid <= i_in_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_word.valid && i_in_word.ready) begin
            r_cmd  <= i_in_word.command;
            r_raw  <= i_in_word.raw_pressed;
            r_idx  <= i_in_word.button_index;
            r_sel  <= i_in_word.counter_select;
            r_wval <= i_in_word.write_value;
            r_clr  <= i_in_word.clear_press_count;
        end
    end

    assign idx_ok   = (r_idx < 4'(BUTTONS));
    assign acc_ok   = idx_ok && r_init;
    assign lane_idx = r_idx[IDX_W-1:0];

    always_comb begin
        n_init     = r_init;
        n_prev_raw = r_prev_raw;
        n_deb      = r_deb;
        if (fire && r_cmd == CMD_SEED) begin
            n_init     = 1'b1;
            n_prev_raw = r_raw;
            n_deb      = r_raw;
        end else if (fire && r_cmd == CMD_TICK && r_init) begin
            n_prev_raw = r_raw;
            n_deb      = (r_deb & (r_raw ^ r_prev_raw)) | (r_raw & ~(r_raw ^ r_prev_raw));
        end
    end

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        always_comb begin
            lane_ctl[b].tick   = fire && r_cmd == CMD_TICK && r_init;
            lane_ctl[b].seed   = fire && r_cmd == CMD_SEED;
            lane_ctl[b].wr_en  = fire && r_cmd == CMD_WRITE && acc_ok &&
                                 lane_idx == IDX_W'(b);
            lane_ctl[b].rd_clr = fire && r_cmd == CMD_READ && acc_ok && r_clr &&
                                 lane_idx == IDX_W'(b);
            lane_ctl[b].sel    = r_sel;
            lane_ctl[b].lim    = r_lim;
            lane_ctl[b].wval   = r_wval;
        end

        bpet_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (lane_ctl[b]),
            .i_was       (r_deb[b]),
            .i_now       (n_deb[b]),
            .i_raw       (r_raw[b]),
            .o_flags     (lane_flags[b]),
            .o_flags_nxt (lane_flags_nxt[b]),
            .o_cnt       (lane_cnt[b])
        );
    end

    always_comb begin
        ab_flags  = '0;
        sel_cnt   = '0;
        sel_flags = '0;
        if (r_abort_btn < 3'(BUTTONS)) begin
            ab_flags = lane_flags_nxt[r_abort_btn[IDX_W-1:0]];
        end
        if (idx_ok) begin
            sel_cnt   = lane_cnt[lane_idx];
            sel_flags = lane_flags[lane_idx];
        end
    end

    always_comb begin
        n_rd_val  = '0;
        n_pressed = 1'b0;
        n_abort   = 1'b0;
        n_idx_err = 1'b0;
        case (r_cmd)
            CMD_TICK: begin
                n_abort = r_init && |(ab_flags & r_abort_mask);
            end
            CMD_READ: begin
                n_idx_err = !idx_ok;
                if (acc_ok) begin
                    n_pressed = sel_flags[0];
                    case (r_sel)
                        SEL_PRESS:     n_rd_val = 16'(sel_cnt.press);
                        SEL_LONG:      n_rd_val = 16'(sel_cnt.long_press);
                        SEL_SHORT_REL: n_rd_val = 16'(sel_cnt.short_rel);
                        SEL_LONG_REL:  n_rd_val = 16'(sel_cnt.long_rel);
                        SEL_REL:       n_rd_val = 16'(sel_cnt.rel);
                        SEL_FLAGS:     n_rd_val = 16'(sel_flags);
                        default:       n_rd_val = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                n_idx_err = !idx_ok;
            end
            default: begin
                n_idx_err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b0;
            r_prev_raw  <= '0;
            r_deb       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_init     <= n_init;
            r_prev_raw <= n_prev_raw;
            r_deb      <= n_deb;
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd_val  <= n_rd_val;
            r_pressed <= n_pressed;
            r_abort   <= n_abort;
            r_idx_err <= n_idx_err;
        end
    end

    assign o_out_word.valid       = r_out_valid;
    assign o_out_word.read_value  = r_rd_val;
    assign o_out_word.pressed     = r_pressed;
    assign o_out_word.abort       = r_abort;
    assign o_out_word.index_error = r_idx_err;

endmodule

@@ dv/button_press_event_tracker_checker.sv @@
`timescale 1ns / 1ps
// Checker for the button press event tracker: watches the command, result and
// configuration ports, tracks the debounce/counter state and compares results.
// Depends on bpet_pkg and bpet_ifs.
module button_press_event_tracker_checker
    import bpet_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    bpet_in_if         i_in_word,
    bpet_out_if        i_out_word,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_long_events
);

    typedef struct packed {
        logic [15:0] read_value;
        logic        pressed;
        logic        abort;
        logic        index_error;
    } t_reply;

    logic [LIM_W-1:0]  long_ticks;
    logic [5:0]        mask_q;
    logic [2:0]        abort_btn;

    logic              seeded;
    logic [5:0]        last_raw;
    logic [5:0]        level;
    logic [HOLD_W-1:0] held   [BUTTONS];
    t_flags            flags  [BUTTONS];
    t_count            counts [5][BUTTONS];

    t_reply            due_replies [$];
    t_reply            want;
    t_reply            got;

    function automatic void clear_counts();
        for (int i = 0; i < BUTTONS; i++) begin
            for (int s = 0; s < 5; s++) begin
                counts[s][i] = '0;
            end
        end
    endfunction

    function automatic void reset_tracker();
        long_ticks = RST_LONG_TICKS;
        mask_q     = RST_ABORT_MASK;
        abort_btn  = RST_ABORT_BUTTON;
        seeded     = 1'b0;
        last_raw   = '0;
        level      = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            held[i]  = '0;
            flags[i] = FL_RELEASED;
        end
        clear_counts();
    endfunction

    function automatic void seed_from_sample(input logic [5:0] raw);
        seeded   = 1'b1;
        last_raw = raw;
        level    = raw;
        for (int i = 0; i < BUTTONS; i++) begin
            if (raw[i]) begin
                flags[i] = FL_PRESSED;
                held[i]  = {1'b0, long_ticks} + 1'b1;
            end else begin
                flags[i] = FL_RELEASED;
                held[i]  = '0;
            end
        end
        clear_counts();
    endfunction

    function automatic void debounce_tick(input logic [5:0] raw);
        logic was_down;
        logic is_down;
        for (int i = 0; i < BUTTONS; i++) begin
            was_down = level[i];
            if (raw[i] == last_raw[i]) begin
                level[i] = raw[i];
            end
            is_down = level[i];
            if (is_down) begin
                if (!was_down) begin
                    held[i]  = '0;
                    flags[i] = FL_PRESSED | FL_PRESS_EV;
                    counts[SEL_PRESS][i] = counts[SEL_PRESS][i] + 1'b1;
                end else if (held[i] < long_ticks) begin
                    flags[i] = FL_PRESSED;
                    held[i]  = held[i] + 1'b1;
                end else if (held[i] == long_ticks) begin
                    flags[i] = FL_PRESSED | FL_LONG_EV;
                    held[i]  = held[i] + 1'b1;
                    counts[SEL_LONG][i] = counts[SEL_LONG][i] + 1'b1;
                    o_long_events++;
                end else begin
                    flags[i] = FL_PRESSED;
                end
            end else if (was_down) begin
                if (held[i] >= long_ticks) begin
                    flags[i] = FL_RELEASED | FL_LONG_REL;
                    counts[SEL_LONG_REL][i] = counts[SEL_LONG_REL][i] + 1'b1;
                end else begin
                    flags[i] = FL_RELEASED | FL_SHORT_REL;
                    counts[SEL_SHORT_REL][i] = counts[SEL_SHORT_REL][i] + 1'b1;
                end
                counts[SEL_REL][i] = counts[SEL_REL][i] + 1'b1;
            end else begin
                flags[i] = FL_RELEASED;
            end
        end
        last_raw = raw;
    endfunction

    function automatic t_reply run_command(input logic [1:0] cmd, input logic [5:0] raw,
                                           input logic [3:0] idx, input logic [2:0] sel,
                                           input logic [15:0] wval, input logic clr);
        t_reply r;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                if (seeded) begin
                    debounce_tick(raw);
                    if (abort_btn < BUTTONS && (flags[abort_btn] & mask_q) != '0) begin
                        r.abort = 1'b1;
                    end
                end
            end
            CMD_SEED: begin
                seed_from_sample(raw);
            end
            default: begin
                if (idx >= BUTTONS) begin
                    r.index_error = 1'b1;
                end else if (seeded && cmd == CMD_READ) begin
                    r.pressed = flags[idx][0];
                    if (sel < SEL_FLAGS) begin
                        r.read_value = counts[sel][idx];
                    end else if (sel == SEL_FLAGS) begin
                        r.read_value = {{(16-FLAG_W){1'b0}}, flags[idx]};
                    end
                    if (clr) begin
                        counts[SEL_PRESS][idx] = '0;
                    end
                end else if (seeded) begin
                    if (sel < SEL_FLAGS) begin
                        counts[sel][idx] = wval;
                    end else if (sel == SEL_FLAGS) begin
                        flags[idx] = wval[FLAG_W-1:0];
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string field, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0h, got %0h", field, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_tracker();
            due_replies.delete();
            o_fail_count  = 0;
            o_checked     = 0;
            o_long_events = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_TICKS:   long_ticks = i_cfg_data;
                    CFG_ABORT_MASK:   mask_q     = i_cfg_data[5:0];
                    CFG_ABORT_BUTTON: abort_btn  = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_in_word.valid && i_in_word.ready) begin
                due_replies.push_back(run_command(i_in_word.command, i_in_word.raw_pressed,
                                                  i_in_word.button_index,
                                                  i_in_word.counter_select,
                                                  i_in_word.write_value,
                                                  i_in_word.clear_press_count));
            end
            if (i_out_word.valid && i_out_word.ready) begin
                got.read_value  = i_out_word.read_value;
                got.pressed     = i_out_word.pressed;
                got.abort       = i_out_word.abort;
                got.index_error = i_out_word.index_error;
                if (due_replies.size() == 0) begin
                    $error("result word with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = due_replies.pop_front();
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("pressed", want.pressed, got.pressed);
                    check_field("abort", want.abort, got.abort);
                    check_field("index_error", want.index_error, got.index_error);
                    o_checked++;
                end
            end
        end
        o_pending = due_replies.size();
    end

endmodule

@@ dv/button_press_event_tracker_core_test.sv @@
`timescale 1ns / 1ps
// Top of the button press event tracker testbench: clock, reset, register
// setup and command stimulus with random idling on both channels.
// Depends on bpet_pkg, bpet_ifs, the core and button_press_event_tracker_checker.
module button_press_event_tracker_core_test;
    import bpet_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int long_events;

    int cycles       = 0;
    bit idle_on      = 1'b0;
    int cur_lpt      = 200;
    int settings     = 1;
    int tick_words   = 0;
    int read_words   = 0;
    int write_words  = 0;
    int seed_words   = 0;

    logic [5:0] btn_level = '0;
    int         hold_left [BUTTONS];

    bpet_in_if  cmd_ch ();
    bpet_out_if reply_ch ();

    button_press_event_tracker_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_word  (cmd_ch),
        .o_out_word (reply_ch)
    );

    button_press_event_tracker_checker tracker_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_word     (cmd_ch),
        .i_out_word    (reply_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_long_events (long_events)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall before each word
    initial begin
        int stall;
        reply_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                reply_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            reply_ch.ready = 1'b1;
            do @(posedge i_clk); while (!(reply_ch.valid && reply_ch.ready));
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [5:0] raw,
                             input logic [3:0] idx, input logic [2:0] sel,
                             input logic [15:0] wval, input logic clr);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            cmd_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.command           = cmd;
        cmd_ch.raw_pressed       = raw;
        cmd_ch.button_index      = idx;
        cmd_ch.counter_select    = sel;
        cmd_ch.write_value       = wval;
        cmd_ch.clear_press_count = clr;
        cmd_ch.valid             = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        case (cmd)
            CMD_TICK:  tick_words++;
            CMD_READ:  read_words++;
            CMD_WRITE: write_words++;
            default:   seed_words++;
        endcase
    endtask

    task automatic wait_for_replies();
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic int draw_hold();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, 3);
            1:       return $urandom_range(cur_lpt, cur_lpt + 3);
            default: return $urandom_range(1, 2 * cur_lpt + 4);
        endcase
    endfunction

    task automatic set_config(input int lpt, input int mask, input int btn);
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = CFG_LONG_TICKS;
        cfg_data = 8'(lpt);
        @(negedge i_clk);
        cfg_idx  = CFG_ABORT_MASK;
        cfg_data = 8'(mask);
        @(negedge i_clk);
        cfg_idx  = CFG_ABORT_BUTTON;
        cfg_data = 8'(btn);
        @(negedge i_clk);
        cfg_we   = 1'b0;
        cur_lpt  = lpt;
        settings++;
        for (int b = 0; b < BUTTONS; b++) begin
            hold_left[b] = draw_hold();
        end
    endtask

    // mostly ticks that follow held/released button levels, with glitches and noise
    task automatic random_word();
        logic [1:0]  cmd;
        logic [5:0]  raw;
        logic [3:0]  idx;
        logic [2:0]  sel;
        logic [15:0] wval;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)      cmd = CMD_TICK;
        else if (pick < 83) cmd = CMD_READ;
        else if (pick < 97) cmd = CMD_WRITE;
        else                cmd = CMD_SEED;
        if (cmd == CMD_TICK) begin
            for (int b = 0; b < BUTTONS; b++) begin
                if (hold_left[b] <= 1) begin
                    btn_level[b] = ~btn_level[b];
                    hold_left[b] = draw_hold();
                end else begin
                    hold_left[b]--;
                end
            end
        end
        raw  = btn_level;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            raw = 6'($urandom);
        end else if (pick < 14) begin
            raw[$urandom_range(0, 5)] = ~raw[$urandom_range(0, 5)];
        end
        if ($urandom_range(0, 99) < 85) idx = 4'($urandom_range(0, BUTTONS - 1));
        else                             idx = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 90) sel = 3'($urandom_range(0, 5));
        else                             sel = 3'($urandom_range(6, 7));
        pick = $urandom_range(0, 99);
        case (pick % 5)
            0:       wval = 16'hFFFF;
            1:       wval = 16'hFFFE;
            2:       wval = 16'h0000;
            default: wval = 16'h8000;
        endcase
        if (pick >= 20) wval = 16'($urandom);
        send_word(cmd, raw, idx, sel, wval, $urandom_range(0, 99) < 30);
    endtask

    task automatic run_phase(input int words);
        for (int k = 0; k < words; k++) begin
            if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            if (k == words / 2) wait_for_replies();
            random_word();
        end
    endtask

    initial begin
        int lpt;
        int mask;
        int btn;
        i_rst_n                  = 1'b0;
        cfg_we                   = 1'b0;
        cfg_idx                  = CFG_LONG_TICKS;
        cfg_data                 = '0;
        cmd_ch.valid             = 1'b0;
        cmd_ch.command           = CMD_TICK;
        cmd_ch.raw_pressed       = '0;
        cmd_ch.button_index      = '0;
        cmd_ch.counter_select    = SEL_PRESS;
        cmd_ch.write_value       = '0;
        cmd_ch.clear_press_count = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // not yet seeded: nothing changes, index errors still flagged
        send_word(CMD_TICK, 6'h3F, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd0, SEL_PRESS, 16'h0000, 1'b1);
        send_word(CMD_WRITE, 6'h00, 4'd0, SEL_PRESS, 16'h1234, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd15, SEL_FLAGS, 16'h0000, 1'b0);

        set_config(2, FL_PRESS_EV | FL_LONG_EV, 0);
        // held buttons at seed count as already past long press
        send_word(CMD_SEED, 6'h2A, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        send_word(CMD_TICK, 6'h2A, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        repeat (5) send_word(CMD_TICK, 6'h01, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        repeat (2) send_word(CMD_TICK, 6'h00, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd0, SEL_LONG, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd1, SEL_LONG_REL, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd0, SEL_FLAGS, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd0, 3'd6, 16'h0000, 1'b1);
        send_word(CMD_READ, 6'h00, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        // press count wraps
        send_word(CMD_WRITE, 6'h00, 4'd0, SEL_PRESS, 16'hFFFF, 1'b0);
        repeat (2) send_word(CMD_TICK, 6'h01, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd0, SEL_PRESS, 16'h0000, 1'b0);
        send_word(CMD_WRITE, 6'h00, 4'd2, SEL_FLAGS, 16'hFFFF, 1'b0);
        send_word(CMD_READ, 6'h00, 4'd2, SEL_FLAGS, 16'h0000, 1'b0);
        send_word(CMD_WRITE, 6'h00, 4'd0, 3'd7, 16'h5555, 1'b0);
        send_word(CMD_WRITE, 6'h00, 4'd6, SEL_PRESS, 16'h5555, 1'b0);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin lpt = 1;   mask = 63;  btn = 5; end
                1: begin lpt = 3;   mask = FL_PRESS_EV; btn = 0; end
                2: begin lpt = 255; mask = FL_LONG_EV | FL_LONG_REL; btn = 3; end
                3: begin
                    lpt  = $urandom_range(1, 8);
                    mask = $urandom_range(0, 63);
                    btn  = 7;
                end
                4: begin lpt = 2;   mask = 0;   btn = 1; end
                5: begin lpt = 5;   mask = FL_SHORT_REL | FL_RELEASED; btn = 2; end
                default: begin
                    lpt  = $urandom_range(1, 12);
                    mask = $urandom_range(0, 63);
                    btn  = $urandom_range(0, BUTTONS - 1);
                end
            endcase
            set_config(lpt, mask, btn);
            run_phase((p == 2) ? 400 : 220);
        end

        wait_for_replies();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d commands: %0d ticks, %0d reads, %0d writes, %0d seeds",
                 tick_words + read_words + write_words + seed_words,
                 tick_words, read_words, write_words, seed_words);
        $display("Compared %0d results across %0d register settings, %0d long presses seen",
                 checked, settings, long_events);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/bpet_pkg.sv
design/bpet_ifs.sv
design/bpet_lane.sv
design/button_press_event_tracker_core.sv
dv/button_press_event_tracker_checker.sv
dv/button_press_event_tracker_core_test.sv
